// ----- hdl/assert_macros.svh -----
// Assertion macros for the graph store checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define AMG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in graph store checker");

// Concurrent assertion that is checked at every clock edge, reset included.
`define AMG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed in graph store checker");

`endif

// ----- hdl/amg_pkg.sv -----
// Shared types and constants of the adjacency matrix graph store.
`timescale 1ns / 1ps
package amg_pkg;

    localparam int MAX_NODES   = 64;
    localparam int IDX_W       = 6;
    localparam int IDX_SLOTS   = 1 << IDX_W;
    localparam int CMD_W       = 3;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD_NODE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_EDGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HAS_EDGE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY_NODE  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] source_node;
        logic [IDX_W-1:0] target_node;
    } amg_request_t;

    typedef struct packed {
        logic             edge_present;
        logic             node_present;
        logic [IDX_W-1:0] neighbor_index;
        logic             neighbor_valid;
        logic             last;
        logic [CNT_W-1:0] node_count;
    } amg_result_t;

    // Classified request handed from the front end to the execution side.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic             src_ok;
        logic             dst_ok;
    } amg_op_t;

endpackage

// ----- hdl/amg_front.sv -----
// Request intake: range classification and a two-entry queue to the back end.
`timescale 1ns / 1ps
module amg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  amg_pkg::amg_request_t s_request,
    input  logic                 s_valid,
    output logic                 s_ready,
    output amg_pkg::amg_op_t     op,
    output logic                 op_valid,
    input  logic                 op_pop
);
    import amg_pkg::*;

    amg_op_t             q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QCNT_W-1:0]   fill_next;
    amg_op_t             in_op;
    logic                push;
    logic                pop;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return int'(idx) < MAX_NODES;
    endfunction

    always_comb begin
        in_op.command = s_request.command;
        in_op.src     = s_request.source_node;
        in_op.dst     = s_request.target_node;
        in_op.src_ok  = in_range(s_request.source_node);
        in_op.dst_ok  = in_range(s_request.target_node);
    end

    assign s_ready  = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign op_valid = fill_reg != '0;
    assign op       = q_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = op_pop && op_valid;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ----- hdl/amg_back.sv -----
// Execution side: row memory read-modify-write, presence bits and neighbor listing.
`timescale 1ns / 1ps
module amg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  amg_pkg::amg_op_t    op,
    input  logic                op_valid,
    output logic                op_pop,
    output amg_pkg::amg_result_t m_result,
    output logic                m_valid,
    input  logic                m_ready
);
    import amg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]           state_reg, state_next;
    amg_op_t              op_reg;
    logic [IDX_SLOTS-1:0] mem [IDX_SLOTS];
    logic [IDX_SLOTS-1:0] rd_row_reg;
    logic                 rd_vld_reg;
    logic [IDX_SLOTS-1:0] row_vld_reg;
    logic [IDX_SLOTS-1:0] present_reg, present_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_SLOTS-1:0] work_reg, work_next;
    amg_result_t          out_data_reg, out_next;
    logic                 out_valid_reg;
    logic                 out_free;
    logic                 out_load;
    logic                 wr_en;
    logic [IDX_SLOTS-1:0] wr_row;
    logic [IDX_SLOTS-1:0] row;
    logic [IDX_SLOTS-1:0] dst_bit;
    logic [IDX_SLOTS-1:0] rest;
    logic                 src_pres;
    logic                 dst_pres;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [IDX_SLOTS-1:0] bits);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = IDX_SLOTS - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign m_result = out_data_reg;
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign op_pop   = (state_reg == ST_IDLE) && op_valid;

    // A row that was never written reads as empty.
    assign row      = rd_vld_reg ? rd_row_reg : '0;
    assign dst_bit  = IDX_SLOTS'(1) << op_reg.dst;
    assign src_pres = op_reg.src_ok && present_reg[op_reg.src];
    assign dst_pres = op_reg.dst_ok && present_reg[op_reg.dst];
    assign rest     = work_reg & (work_reg - IDX_SLOTS'(1));

    always_comb begin
        state_next   = state_reg;
        present_next = present_reg;
        count_next   = count_reg;
        work_next    = work_reg;
        wr_en        = 1'b0;
        wr_row       = row;
        out_load     = 1'b0;
        out_next     = '0;
        out_next.node_present = src_pres;
        out_next.last         = 1'b1;
        out_next.node_count   = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg.command == CMD_LIST && src_pres && row != '0) begin
                    work_next  = row;
                    state_next = ST_LIST;
                end else if (out_free) begin
                    unique case (op_reg.command)
                        CMD_ADD_NODE: begin
                            if (op_reg.src_ok && !present_reg[op_reg.src]) begin
                                present_next[op_reg.src] = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            out_next.node_present = op_reg.src_ok;
                        end
                        CMD_ADD_EDGE: begin
                            if (src_pres && dst_pres) begin
                                wr_en  = 1'b1;
                                wr_row = row | dst_bit;
                                out_next.edge_present = 1'b1;
                            end
                        end
                        CMD_REMOVE_EDGE: begin
                            if (op_reg.src_ok && op_reg.dst_ok) begin
                                wr_en  = 1'b1;
                                wr_row = row & ~dst_bit;
                            end
                        end
                        CMD_HAS_EDGE: begin
                            out_next.edge_present = op_reg.src_ok && op_reg.dst_ok &&
                                                    row[op_reg.dst];
                        end
                        default: begin
                        end
                    endcase
                    out_next.node_count = count_next;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    out_next.neighbor_valid = 1'b1;
                    out_next.neighbor_index = lowest_set(work_reg);
                    out_next.last           = rest == '0;
                    out_load  = 1'b1;
                    work_next = rest;
                    if (rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            count_reg     <= '0;
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            if (wr_en) begin
                row_vld_reg[op_reg.src] <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (op_pop) begin
            op_reg     <= op;
            rd_vld_reg <= row_vld_reg[op.src];
        end
        if (out_load) begin
            out_data_reg <= out_next;
        end
    end

    // Edge row memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[op_reg.src] <= wr_row;
        end
        if (op_pop) begin
            rd_row_reg <= mem[op.src];
        end
    end

endmodule

// ----- hdl/adjacency_matrix_graph_store.sv -----
// Top level of the adjacency matrix graph store.
//
//   channel   direction   handshake            payload
//   s_        request     s_valid / s_ready    s_request (amg_request_t)
//   m_        result      m_valid / m_ready    m_result  (amg_result_t)
//
// In the execution side a request reads its edge row from the row memory as it is popped
// in the idle state, then updates the row and loads the result register once it is free.
// A listing gives one result per cycle per set bit while the result register is free.
// Synchronous active-low reset clears presence bits, node count and row valid bits;
// no clearing pass is needed. A two-entry request queue keeps intake running while the
// result register waits on m_ready.
`timescale 1ns / 1ps
module adjacency_matrix_graph_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  amg_pkg::amg_request_t s_request,
    input  logic                 s_valid,
    output logic                 s_ready,
    output amg_pkg::amg_result_t m_result,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import amg_pkg::*;

    amg_op_t op;
    logic    op_valid;
    logic    op_pop;

    amg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_request (s_request),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .op        (op),
        .op_valid  (op_valid),
        .op_pop    (op_pop)
    );

    amg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .op_valid (op_valid),
        .op_pop   (op_pop),
        .m_result (m_result),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

endmodule

// ----- hdl/amg_checker.sv -----
// Port-level checker for the graph store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module amg_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input amg_pkg::amg_request_t s_request,
    input logic                 s_valid,
    input logic                 s_ready,
    input amg_pkg::amg_result_t m_result,
    input logic                 m_valid,
    input logic                 m_ready
);
    import amg_pkg::*;

    // The result register is empty right after reset.
    `AMG_ASSERT(a_idle_after_reset, aclk, aresetn, !$past(aresetn) |-> !m_valid)

    // A stalled result holds.
    `AMG_ASSERT(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_result))

    `AMG_ASSERT(a_count_bound, aclk, aresetn, m_valid |-> int'(m_result.node_count) <= MAX_NODES)

    // An empty neighbor slot carries index zero.
    `AMG_ASSERT(a_empty_index, aclk, aresetn, m_valid && !m_result.neighbor_valid |-> m_result.neighbor_index == '0)

    // Edge answers and neighbor entries never share one result.
    `AMG_ASSERT(a_kind_excl, aclk, aresetn, m_valid |-> !(m_result.edge_present && m_result.neighbor_valid))

endmodule

bind adjacency_matrix_graph_store amg_checker u_amg_checker (.*);
